// File: src/usbces_pkg.sv
// Shared types and codes of the endpoint-zero control sequencer.
// No dependencies; imported by every module of the block.
package usbces_pkg;

    typedef enum logic [1:0]
    {
        OP_SETUP     = 2'd0,
        OP_IN        = 2'd1,
        OP_OUT       = 2'd2,
        OP_BUS_RESET = 2'd3
    } op_t;

    // Buffer arm directions
    localparam logic [1:0] ARM_NONE = 2'd0;
    localparam logic [1:0] ARM_RX   = 2'd1;
    localparam logic [1:0] ARM_TX   = 2'd2;

    // Data sources for an armed buffer
    localparam logic [2:0] SRC_NONE        = 3'd0;
    localparam logic [2:0] SRC_SETUP       = 3'd1;
    localparam logic [2:0] SRC_DEVICE_DESC = 3'd2;
    localparam logic [2:0] SRC_CONFIG_DESC = 3'd3;
    localparam logic [2:0] SRC_CONFIG_BYTE = 3'd4;
    localparam logic [2:0] SRC_LINE_CODING = 3'd5;

    // Requests: bRequest in the high byte, bmRequestType in the low byte
    localparam logic [15:0] REQ_GET_DESCRIPTOR         = 16'h0680;
    localparam logic [15:0] REQ_GET_CONFIGURATION      = 16'h0880;
    localparam logic [15:0] REQ_SET_CONFIGURATION      = 16'h0900;
    localparam logic [15:0] REQ_SET_ADDRESS            = 16'h0500;
    localparam logic [15:0] REQ_SET_LINE_CODING        = 16'h2021;
    localparam logic [15:0] REQ_SET_CONTROL_LINE_STATE = 16'h2221;

    localparam logic [7:0] DESC_TYPE_DEVICE = 8'd1;
    localparam logic [7:0] DESC_TYPE_CONFIG = 8'd2;
    localparam logic [15:0] CONFIG_VALUE_ONE = 16'd1;

    // Configuration register indexes
    localparam logic [1:0] REG_DEVICE_DESC_LEN = 2'd0;
    localparam logic [1:0] REG_CONFIG_DESC_LEN = 2'd1;
    localparam logic [1:0] REG_MAX_PACKET_SIZE = 2'd2;
    localparam logic [1:0] REG_LINE_CODING_LEN = 2'd3;

    localparam logic [7:0]  DEVICE_DESC_LEN_RESET = 8'd18;
    localparam logic [15:0] CONFIG_DESC_LEN_RESET = 16'd67;
    localparam logic [6:0]  MAX_PACKET_SIZE_RESET = 7'd64;
    localparam logic [7:0]  LINE_CODING_LEN_RESET = 8'd7;

    localparam int PACKET_BYTES_MAX_DEFAULT = 64;
    localparam logic [6:0] SETUP_PACKET_BYTES = 7'd8;

    typedef struct packed
    {
        op_t         op;
        logic        received_toggle;
        logic [15:0] request;
        logic [15:0] setup_value;
        logic [15:0] setup_length;
    } item_t;

    typedef struct packed
    {
        logic [7:0]  device_desc_len;
        logic [15:0] config_desc_len;
        logic [6:0]  packet_cap;
        logic [7:0]  line_coding_len;
    } cfg_t;

    typedef struct packed
    {
        logic [1:0]  arm;
        logic        arm_bank;
        logic [6:0]  arm_count;
        logic        arm_toggle;
        logic [2:0]  arm_source;
        logic [15:0] arm_offset;
        logic        stall_res;
        logic        address_write;
        logic [6:0]  device_address;
        logic        configured_value;
        logic [7:0]  line_state_value;
        logic [2:0]  phase_now;
    } result_t;

endpackage

// File: src/usbces_cfg.sv
// Configuration registers of the control sequencer, with the packet size
// held already clamped. Depends on usbces_pkg.
module usbces_cfg #(
    parameter int PACKET_BYTES_MAX = usbces_pkg::PACKET_BYTES_MAX_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [1:0]           wr_index,
    input  logic [15:0]          wr_data,
    output usbces_pkg::cfg_t     cfg
);
    import usbces_pkg::*;

    localparam logic [6:0] CapMax = 7'(PACKET_BYTES_MAX);

    logic [7:0]  dev_len_reg;
    logic [15:0] cfg_len_reg;
    logic [6:0]  cap_reg;
    logic [7:0]  lc_len_reg;

    function automatic logic [6:0] clamp_cap(input logic [6:0] m);
        logic [6:0] r;
        begin
            r = m;
            if (m < SETUP_PACKET_BYTES)
            begin
                r = SETUP_PACKET_BYTES;
            end
            else if (m > CapMax)
            begin
                r = CapMax;
            end
            return r;
        end
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_len_reg <= DEVICE_DESC_LEN_RESET;
            cfg_len_reg <= CONFIG_DESC_LEN_RESET;
            cap_reg     <= clamp_cap(MAX_PACKET_SIZE_RESET);
            lc_len_reg  <= LINE_CODING_LEN_RESET;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_DEVICE_DESC_LEN: dev_len_reg <= wr_data[7:0];
                REG_CONFIG_DESC_LEN: cfg_len_reg <= wr_data;
                REG_MAX_PACKET_SIZE: cap_reg     <= clamp_cap(wr_data[6:0]);
                REG_LINE_CODING_LEN: lc_len_reg  <= wr_data[7:0];
                default:             ;
            endcase
        end
    end

    assign cfg.device_desc_len = dev_len_reg;
    assign cfg.config_desc_len = cfg_len_reg;
    assign cfg.packet_cap      = cap_reg;
    assign cfg.line_coding_len = lc_len_reg;

endmodule

// File: src/usbces_step.sv
// Transfer state of endpoint zero and the single-pass update for one beat:
// bus reset, setup decode, data stage, status stage, re-arm of the setup buffer.
// Depends on usbces_pkg.
module usbces_step (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  usbces_pkg::item_t    item,
    input  usbces_pkg::cfg_t     cfg,
    output usbces_pkg::result_t  res
);
    import usbces_pkg::*;

    typedef enum logic [2:0]
    {
        PH_SETUP      = 3'd0,
        PH_DATA_IN    = 3'd1,
        PH_DATA_OUT   = 3'd2,
        PH_STATUS_IN  = 3'd3,
        PH_STATUS_OUT = 3'd4,
        PH_COMPLETE   = 3'd5
    } phase_t;

    phase_t      phase_reg, phase_next, ph;
    logic [2:0]  src_reg, src_next;
    logic [15:0] off_reg, off_next;
    logic [15:0] rem_reg, rem_next;
    logic [6:0]  req_addr_reg, req_addr_next;
    logic [6:0]  cur_addr_reg, cur_addr_next;
    logic        rx_bank_reg, rx_bank_next;
    logic        tx_bank_reg, tx_bank_next;
    logic        cfg_val_reg, cfg_val_next;
    logic [7:0]  line_state_reg, line_state_next;

    logic [15:0] base_len;
    logic [6:0]  pkt_n;
    logic        is_setup, is_in, is_out;

    assign is_setup = (item.op == OP_SETUP);
    assign is_in    = (item.op == OP_IN);
    assign is_out   = (item.op == OP_OUT);

    always_comb
    begin
        ph              = phase_reg;
        src_next        = src_reg;
        off_next        = off_reg;
        rem_next        = rem_reg;
        req_addr_next   = req_addr_reg;
        cur_addr_next   = cur_addr_reg;
        rx_bank_next    = rx_bank_reg;
        tx_bank_next    = tx_bank_reg;
        cfg_val_next    = cfg_val_reg;
        line_state_next = line_state_reg;
        base_len        = '0;
        pkt_n           = '0;
        res             = '0;

        if (item.op == OP_BUS_RESET)
        begin
            ph             = PH_SETUP;
            req_addr_next  = '0;
            cur_addr_next  = '0;
            src_next       = SRC_NONE;
            off_next       = '0;
            rem_next       = '0;
            tx_bank_next   = 1'b0;
            rx_bank_next   = 1'b1;
            res.arm        = ARM_RX;
            res.arm_count  = SETUP_PACKET_BYTES;
            res.arm_source = SRC_SETUP;
            res.address_write = 1'b1;
        end
        else
        begin
            // Decode only a setup beat that arrives in the setup phase
            if (ph == PH_SETUP && is_setup)
            begin
                src_next = SRC_NONE;
                off_next = '0;
                case (item.request)
                    REQ_GET_DESCRIPTOR:
                    begin
                        if (item.setup_value[15:8] == DESC_TYPE_DEVICE)
                        begin
                            src_next = SRC_DEVICE_DESC;
                            base_len = {8'd0, cfg.device_desc_len};
                            ph       = PH_DATA_IN;
                        end
                        else if (item.setup_value[15:8] == DESC_TYPE_CONFIG)
                        begin
                            src_next = SRC_CONFIG_DESC;
                            base_len = cfg.config_desc_len;
                            ph       = PH_DATA_IN;
                        end
                        else
                        begin
                            res.stall_res = 1'b1;
                            ph            = PH_COMPLETE;
                        end
                    end
                    REQ_GET_CONFIGURATION:
                    begin
                        src_next = SRC_CONFIG_BYTE;
                        base_len = 16'd1;
                        ph       = PH_DATA_IN;
                    end
                    REQ_SET_CONFIGURATION:
                    begin
                        if (item.setup_value != CONFIG_VALUE_ONE)
                        begin
                            res.stall_res = 1'b1;
                            ph            = PH_COMPLETE;
                        end
                        else
                        begin
                            cfg_val_next = 1'b1;
                            ph           = PH_DATA_OUT;
                        end
                    end
                    REQ_SET_ADDRESS:
                    begin
                        req_addr_next = item.setup_value[6:0];
                        ph            = PH_DATA_OUT;
                    end
                    REQ_SET_CONTROL_LINE_STATE:
                    begin
                        line_state_next = item.setup_value[7:0];
                        ph              = PH_DATA_OUT;
                    end
                    REQ_SET_LINE_CODING:
                    begin
                        src_next = SRC_LINE_CODING;
                        base_len = {8'd0, cfg.line_coding_len};
                        ph       = PH_DATA_OUT;
                    end
                    default:
                    begin
                        res.stall_res = 1'b1;
                        ph            = PH_COMPLETE;
                    end
                endcase
                // Clamp to what the host allows
                rem_next = (item.setup_length < base_len) ? item.setup_length : base_len;
            end

            pkt_n = (rem_next < {9'd0, cfg.packet_cap}) ? rem_next[6:0] : cfg.packet_cap;

            if (ph == PH_DATA_IN && (is_in || is_setup))
            begin
                if (pkt_n != '0)
                begin
                    res.arm        = ARM_TX;
                    res.arm_bank   = tx_bank_reg;
                    res.arm_count  = pkt_n;
                    res.arm_toggle = ~item.received_toggle;
                    res.arm_source = src_next;
                    res.arm_offset = off_next;
                    off_next       = off_next + {9'd0, pkt_n};
                    rem_next       = rem_next - {9'd0, pkt_n};
                    tx_bank_next   = ~tx_bank_reg;
                end
                else
                begin
                    // Zero-length status packet from the host
                    res.arm        = ARM_RX;
                    res.arm_bank   = rx_bank_reg;
                    res.arm_toggle = 1'b1;
                    rx_bank_next   = ~rx_bank_reg;
                    ph             = PH_STATUS_IN;
                end
            end

            if (ph == PH_DATA_OUT && (is_out || is_setup))
            begin
                if (pkt_n != '0)
                begin
                    res.arm        = ARM_RX;
                    res.arm_bank   = rx_bank_reg;
                    res.arm_count  = pkt_n;
                    res.arm_toggle = ~item.received_toggle;
                    res.arm_source = src_next;
                    res.arm_offset = off_next;
                    off_next       = off_next + {9'd0, pkt_n};
                    rem_next       = rem_next - {9'd0, pkt_n};
                    rx_bank_next   = ~rx_bank_reg;
                end
                else
                begin
                    res.arm        = ARM_TX;
                    res.arm_bank   = tx_bank_reg;
                    res.arm_toggle = 1'b1;
                    tx_bank_next   = ~tx_bank_reg;
                    ph             = PH_STATUS_OUT;
                end
            end

            // Status stage done: apply the new address
            if ((ph == PH_STATUS_IN && is_out) || (ph == PH_STATUS_OUT && is_in))
            begin
                if (cur_addr_reg != req_addr_next)
                begin
                    cur_addr_next     = req_addr_next;
                    res.address_write = 1'b1;
                end
                ph = PH_COMPLETE;
            end

            if (ph == PH_COMPLETE)
            begin
                res.arm        = ARM_RX;
                res.arm_bank   = rx_bank_next;
                res.arm_count  = SETUP_PACKET_BYTES;
                res.arm_toggle = 1'b0;
                res.arm_source = SRC_SETUP;
                res.arm_offset = '0;
                rx_bank_next   = ~rx_bank_next;
                ph             = PH_SETUP;
            end
        end

        phase_next           = ph;
        res.device_address   = cur_addr_next;
        res.configured_value = cfg_val_next;
        res.line_state_value = line_state_next;
        res.phase_now        = ph;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_SETUP;
            src_reg        <= SRC_NONE;
            off_reg        <= '0;
            rem_reg        <= '0;
            req_addr_reg   <= '0;
            cur_addr_reg   <= '0;
            rx_bank_reg    <= 1'b0;
            tx_bank_reg    <= 1'b0;
            cfg_val_reg    <= 1'b0;
            line_state_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg      <= phase_next;
            src_reg        <= src_next;
            off_reg        <= off_next;
            rem_reg        <= rem_next;
            req_addr_reg   <= req_addr_next;
            cur_addr_reg   <= cur_addr_next;
            rx_bank_reg    <= rx_bank_next;
            tx_bank_reg    <= tx_bank_next;
            cfg_val_reg    <= cfg_val_next;
            line_state_reg <= line_state_next;
        end
    end

endmodule

// File: src/usb_control_endpoint_sequencer.sv
// Top level of the endpoint-zero control sequencer: input register, result
// register and handshakes. Depends on usbces_pkg, usbces_cfg, usbces_step.
//
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------------------
//  in      | in_valid / in_ready  | op, received_toggle, request, setup_value,
//          |                      | setup_length
//  out     | out_valid/out_ready  | arm, arm_bank, arm_count, arm_toggle,
//          |                      | arm_source, arm_offset, stall_res,
//          |                      | address_write, device_address,
//          |                      | configured_value, line_state_value, phase_now
//  cfg     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// One beat per cycle sustained while out_ready is high; a result passes through
// the input register, then one pass of the step logic into the result
// register.
// Reset clears the transfer state, the handshake flags and the configuration
// registers to their defaults. cfg_ready is always high.
// A stalled result holds in the result register; one more input beat waits in
// the input register before in_ready drops.
module usb_control_endpoint_sequencer #(
    parameter int PACKET_BYTES_MAX = usbces_pkg::PACKET_BYTES_MAX_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic        received_toggle,
    input  logic [15:0] request,
    input  logic [15:0] setup_value,
    input  logic [15:0] setup_length,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  arm,
    output logic        arm_bank,
    output logic [6:0]  arm_count,
    output logic        arm_toggle,
    output logic [2:0]  arm_source,
    output logic [15:0] arm_offset,
    output logic        stall_res,
    output logic        address_write,
    output logic [6:0]  device_address,
    output logic        configured_value,
    output logic [7:0]  line_state_value,
    output logic [2:0]  phase_now,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import usbces_pkg::*;

    item_t   item_reg;
    logic    in_full_reg;
    result_t res_reg;
    logic    out_valid_reg;
    result_t res_next;
    cfg_t    cfg;
    logic    advance;

    assign cfg_ready = 1'b1;
    assign advance   = in_full_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_full_reg || advance;

    usbces_cfg #(
        .PACKET_BYTES_MAX (PACKET_BYTES_MAX)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    usbces_step u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item_reg),
        .cfg     (cfg),
        .res     (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                in_full_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_full_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: load on a beat, hold otherwise
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.op              <= op_t'(op);
            item_reg.received_toggle <= received_toggle;
            item_reg.request         <= request;
            item_reg.setup_value     <= setup_value;
            item_reg.setup_length    <= setup_length;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign arm              = res_reg.arm;
    assign arm_bank         = res_reg.arm_bank;
    assign arm_count        = res_reg.arm_count;
    assign arm_toggle       = res_reg.arm_toggle;
    assign arm_source       = res_reg.arm_source;
    assign arm_offset       = res_reg.arm_offset;
    assign stall_res        = res_reg.stall_res;
    assign address_write    = res_reg.address_write;
    assign device_address   = res_reg.device_address;
    assign configured_value = res_reg.configured_value;
    assign line_state_value = res_reg.line_state_value;
    assign phase_now        = res_reg.phase_now;

endmodule

// File: test/usb_control_endpoint_sequencer_test.sv
// Self-checking bench for the endpoint-zero control sequencer: scripted and random
// control transfers, bus resets and register writes under random gaps and stalls.
// Depends on usbces_pkg and usb_control_endpoint_sequencer.
module usb_control_endpoint_sequencer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import usbces_pkg::*;

    localparam int PACKET_CAP       = 64;
    localparam int MIN_PACKET_BYTES = 8;
    localparam int SETTLE_CYCLES    = 4;
    localparam int RANDOM_STAGES    = 8;
    localparam int STAGE_TOKENS     = 175;

    localparam logic [2:0] PH_SETUP      = 3'd0;
    localparam logic [2:0] PH_DATA_IN    = 3'd1;
    localparam logic [2:0] PH_DATA_OUT   = 3'd2;
    localparam logic [2:0] PH_STATUS_IN  = 3'd3;
    localparam logic [2:0] PH_STATUS_OUT = 3'd4;
    localparam logic [2:0] PH_COMPLETE   = 3'd5;

    typedef struct packed
    {
        logic        is_reg_write;
        item_t       token;
        logic [1:0]  reg_index;
        logic [15:0] reg_data;
    } host_event_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  op = OP_SETUP;
    logic        received_toggle = 1'b0;
    logic [15:0] request = '0;
    logic [15:0] setup_value = '0;
    logic [15:0] setup_length = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  arm;
    logic        arm_bank;
    logic [6:0]  arm_count;
    logic        arm_toggle;
    logic [2:0]  arm_source;
    logic [15:0] arm_offset;
    logic        stall_res;
    logic        address_write;
    logic [6:0]  device_address;
    logic        configured_value;
    logic [7:0]  line_state_value;
    logic [2:0]  phase_now;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_DEVICE_DESC_LEN;
    logic [15:0] cfg_data = '0;

    host_event_t token_script[$];
    result_t     pending_arms[$];
    int          token_total = 0;
    int          arm_errors = 0;
    logic        in_taken = 1'b0;
    logic        cfg_taken = 1'b0;

    // Predicted endpoint state and register copies
    logic [2:0]  ph_q;
    logic [2:0]  src_q;
    logic [15:0] offset_q;
    logic [15:0] remain_q;
    logic [6:0]  req_addr_q;
    logic [6:0]  cur_addr_q;
    logic        rx_bank_q;
    logic        tx_bank_q;
    logic        cfg_val_q;
    logic [7:0]  line_state_q;
    logic [7:0]  dev_len_r;
    logic [15:0] cfg_len_r;
    logic [6:0]  mps_r;
    logic [7:0]  lc_len_r;

    // Register values as the stimulus builder sees them
    logic [7:0]  gen_dev_len = DEVICE_DESC_LEN_RESET;
    logic [15:0] gen_cfg_len = CONFIG_DESC_LEN_RESET;
    logic [6:0]  gen_mps = MAX_PACKET_SIZE_RESET;
    logic [7:0]  gen_lc_len = LINE_CODING_LEN_RESET;

    usb_control_endpoint_sequencer #(
        .PACKET_BYTES_MAX(PACKET_CAP)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .op(op),
        .received_toggle(received_toggle),
        .request(request),
        .setup_value(setup_value),
        .setup_length(setup_length),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .arm(arm),
        .arm_bank(arm_bank),
        .arm_count(arm_count),
        .arm_toggle(arm_toggle),
        .arm_source(arm_source),
        .arm_offset(arm_offset),
        .stall_res(stall_res),
        .address_write(address_write),
        .device_address(device_address),
        .configured_value(configured_value),
        .line_state_value(line_state_value),
        .phase_now(phase_now),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [15:0] packet_limit(input logic [6:0] size);
        if (int'(size) < MIN_PACKET_BYTES)
            return 16'(MIN_PACKET_BYTES);
        if (int'(size) > PACKET_CAP)
            return 16'(PACKET_CAP);
        return {9'd0, size};
    endfunction

    function automatic int draw_gap(input logic calm);
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic string describe_arm(input result_t r);
        return {$sformatf("arm=%0d bank=%0d count=%0d tog=%0d src=%0d off=%0d stall=%0d",
                          r.arm, r.arm_bank, r.arm_count, r.arm_toggle, r.arm_source,
                          r.arm_offset, r.stall_res),
                $sformatf(" awr=%0d addr=%0d cfg=%0d line=%0h phase=%0d",
                          r.address_write, r.device_address, r.configured_value,
                          r.line_state_value, r.phase_now)};
    endfunction

    task automatic apply_reg_write(input logic [1:0] index, input logic [15:0] data);
        case (index)
            REG_DEVICE_DESC_LEN: dev_len_r = data[7:0];
            REG_CONFIG_DESC_LEN: cfg_len_r = data;
            REG_MAX_PACKET_SIZE: mps_r = data[6:0];
            REG_LINE_CODING_LEN: lc_len_r = data[7:0];
            default: ;
        endcase
    endtask

    // Advance the predicted endpoint by one token and build the arm action it causes.
    task automatic predict_arm(input item_t tok, output result_t res);
        logic [15:0] cap;
        logic [15:0] n;
        logic        refused;
        logic [2:0]  next_ph;
        res = '0;
        cap = packet_limit(mps_r);
        if (tok.op == OP_BUS_RESET)
        begin
            ph_q = PH_SETUP;
            req_addr_q = '0;
            cur_addr_q = '0;
            src_q = SRC_NONE;
            offset_q = '0;
            remain_q = '0;
            tx_bank_q = 1'b0;
            res.arm = ARM_RX;
            res.arm_count = SETUP_PACKET_BYTES;
            res.arm_source = SRC_SETUP;
            res.address_write = 1'b1;
            rx_bank_q = 1'b1;
        end
        else
        begin
            if (ph_q == PH_SETUP && tok.op == OP_SETUP)
            begin
                refused = 1'b0;
                next_ph = PH_DATA_IN;
                src_q = SRC_NONE;
                offset_q = '0;
                remain_q = '0;
                case (tok.request)
                    REQ_GET_DESCRIPTOR:
                    begin
                        if (tok.setup_value[15:8] == DESC_TYPE_DEVICE)
                        begin
                            src_q = SRC_DEVICE_DESC;
                            remain_q = {8'd0, dev_len_r};
                        end
                        else if (tok.setup_value[15:8] == DESC_TYPE_CONFIG)
                        begin
                            src_q = SRC_CONFIG_DESC;
                            remain_q = cfg_len_r;
                        end
                        else
                            refused = 1'b1;
                    end
                    REQ_GET_CONFIGURATION:
                    begin
                        src_q = SRC_CONFIG_BYTE;
                        remain_q = 16'd1;
                    end
                    REQ_SET_CONFIGURATION:
                    begin
                        next_ph = PH_DATA_OUT;
                        if (tok.setup_value != CONFIG_VALUE_ONE)
                            refused = 1'b1;
                        else
                            cfg_val_q = 1'b1;
                    end
                    REQ_SET_ADDRESS:
                    begin
                        next_ph = PH_DATA_OUT;
                        req_addr_q = tok.setup_value[6:0];
                    end
                    REQ_SET_CONTROL_LINE_STATE:
                    begin
                        next_ph = PH_DATA_OUT;
                        line_state_q = tok.setup_value[7:0];
                    end
                    REQ_SET_LINE_CODING:
                    begin
                        next_ph = PH_DATA_OUT;
                        src_q = SRC_LINE_CODING;
                        remain_q = {8'd0, lc_len_r};
                    end
                    default: refused = 1'b1;
                endcase
                // the host never gets more than wLength
                if (tok.setup_length < remain_q)
                    remain_q = tok.setup_length;
                ph_q = refused ? PH_COMPLETE : next_ph;
                res.stall_res = refused;
            end
            if (ph_q == PH_DATA_IN && (tok.op == OP_IN || tok.op == OP_SETUP))
            begin
                n = (remain_q < cap) ? remain_q : cap;
                if (n != 0)
                begin
                    res.arm = ARM_TX;
                    res.arm_bank = tx_bank_q;
                    res.arm_count = n[6:0];
                    res.arm_toggle = ~tok.received_toggle;
                    res.arm_source = src_q;
                    res.arm_offset = offset_q;
                    offset_q = offset_q + n;
                    remain_q = remain_q - n;
                    tx_bank_q = ~tx_bank_q;
                end
                else
                begin
                    res.arm = ARM_RX;
                    res.arm_bank = rx_bank_q;
                    res.arm_toggle = 1'b1;
                    rx_bank_q = ~rx_bank_q;
                    ph_q = PH_STATUS_IN;
                end
            end
            if (ph_q == PH_DATA_OUT && (tok.op == OP_OUT || tok.op == OP_SETUP))
            begin
                n = (remain_q < cap) ? remain_q : cap;
                if (n != 0)
                begin
                    res.arm = ARM_RX;
                    res.arm_bank = rx_bank_q;
                    res.arm_count = n[6:0];
                    res.arm_toggle = ~tok.received_toggle;
                    res.arm_source = src_q;
                    res.arm_offset = offset_q;
                    offset_q = offset_q + n;
                    remain_q = remain_q - n;
                    rx_bank_q = ~rx_bank_q;
                end
                else
                begin
                    res.arm = ARM_TX;
                    res.arm_bank = tx_bank_q;
                    res.arm_toggle = 1'b1;
                    tx_bank_q = ~tx_bank_q;
                    ph_q = PH_STATUS_OUT;
                end
            end
            // the new address only takes hold once the status stage is done
            if ((ph_q == PH_STATUS_IN && tok.op == OP_OUT) ||
                (ph_q == PH_STATUS_OUT && tok.op == OP_IN))
            begin
                if (cur_addr_q != req_addr_q)
                begin
                    cur_addr_q = req_addr_q;
                    res.address_write = 1'b1;
                end
                ph_q = PH_COMPLETE;
            end
            if (ph_q == PH_COMPLETE)
            begin
                res.arm = ARM_RX;
                res.arm_bank = rx_bank_q;
                res.arm_count = SETUP_PACKET_BYTES;
                res.arm_toggle = 1'b0;
                res.arm_source = SRC_SETUP;
                res.arm_offset = '0;
                rx_bank_q = ~rx_bank_q;
                ph_q = PH_SETUP;
            end
        end
        res.device_address = cur_addr_q;
        res.configured_value = cfg_val_q;
        res.line_state_value = line_state_q;
        res.phase_now = ph_q;
    endtask

    task automatic add_token(input op_t kind, input logic [15:0] req, input logic [15:0] val,
                             input logic [15:0] len);
        host_event_t ev;
        ev = '0;
        ev.token.op = kind;
        ev.token.received_toggle = 1'($urandom_range(0, 1));
        ev.token.request = req;
        ev.token.setup_value = val;
        ev.token.setup_length = len;
        token_script.push_back(ev);
        token_total++;
    endtask

    task automatic add_reg_write(input logic [1:0] index, input logic [15:0] data);
        host_event_t ev;
        ev = '0;
        ev.is_reg_write = 1'b1;
        ev.reg_index = index;
        ev.reg_data = data;
        token_script.push_back(ev);
        case (index)
            REG_DEVICE_DESC_LEN: gen_dev_len = data[7:0];
            REG_CONFIG_DESC_LEN: gen_cfg_len = data;
            REG_MAX_PACKET_SIZE: gen_mps = data[6:0];
            REG_LINE_CODING_LEN: gen_lc_len = data[7:0];
            default: ;
        endcase
    endtask

    // Queue a control transfer: setup, then, unless refused, enough data beats and status.
    task automatic add_transfer(input logic [15:0] req, input logic [15:0] val,
                                input logic [15:0] len);
        int   remain;
        int   cap;
        int   extra;
        op_t  data_op;
        logic refused;
        remain = 0;
        refused = 1'b0;
        data_op = OP_IN;
        cap = int'(packet_limit(gen_mps));
        case (req)
            REQ_GET_DESCRIPTOR:
            begin
                if (val[15:8] == DESC_TYPE_DEVICE)
                    remain = int'(gen_dev_len);
                else if (val[15:8] == DESC_TYPE_CONFIG)
                    remain = int'(gen_cfg_len);
                else
                    refused = 1'b1;
            end
            REQ_GET_CONFIGURATION: remain = 1;
            REQ_SET_CONFIGURATION:
            begin
                data_op = OP_OUT;
                refused = (val != CONFIG_VALUE_ONE);
            end
            REQ_SET_ADDRESS, REQ_SET_CONTROL_LINE_STATE: data_op = OP_OUT;
            REQ_SET_LINE_CODING:
            begin
                data_op = OP_OUT;
                remain = int'(gen_lc_len);
            end
            default: refused = 1'b1;
        endcase
        // keep long descriptor reads at small packet sizes from eating the run
        if (((int'(len) < remain) ? int'(len) : remain) > 40 * cap)
            len = 16'($urandom_range(0, 300));
        if (int'(len) < remain)
            remain = int'(len);
        add_token(OP_SETUP, req, val, len);
        if (!refused)
        begin
            extra = (remain + cap - 1) / cap;
            repeat (extra)
                add_token(($urandom_range(0, 9) == 0) ? OP_SETUP : data_op,
                          16'($urandom), 16'($urandom), 16'($urandom));
            add_token((data_op == OP_IN) ? OP_OUT : OP_IN,
                      16'($urandom), 16'($urandom), 16'($urandom));
        end
    endtask

    always @(negedge clk)
    begin : host_drive
        logic        nxt_in_valid;
        logic        nxt_cfg_valid;
        host_event_t ev;
        int          host_gap;
        int          host_calm;
        int          idle_run;
        nxt_in_valid = in_valid;
        nxt_cfg_valid = cfg_valid;
        if (rst_n)
        begin
            if (in_valid && in_taken)
                nxt_in_valid = 1'b0;
            if (cfg_valid && cfg_taken)
                nxt_cfg_valid = 1'b0;
            if (pending_arms.size() == 0 && !nxt_in_valid)
                idle_run = (idle_run < SETTLE_CYCLES) ? idle_run + 1 : idle_run;
            else
                idle_run = 0;
            if (host_calm > 0)
                host_calm--;
            else if ($urandom_range(0, 299) == 0)
                host_calm = $urandom_range(40, 160);
            if (!nxt_in_valid && !nxt_cfg_valid && token_script.size() != 0)
            begin
                ev = token_script[0];
                if (host_gap > 0)
                    host_gap--;
                else if (!ev.is_reg_write)
                begin
                    void'(token_script.pop_front());
                    op <= ev.token.op;
                    received_toggle <= ev.token.received_toggle;
                    request <= ev.token.request;
                    setup_value <= ev.token.setup_value;
                    setup_length <= ev.token.setup_length;
                    nxt_in_valid = 1'b1;
                    host_gap = draw_gap(host_calm > 0);
                end
                else if (idle_run >= SETTLE_CYCLES)
                begin
                    // registers change only with the block drained
                    void'(token_script.pop_front());
                    cfg_index <= ev.reg_index;
                    cfg_data <= ev.reg_data;
                    nxt_cfg_valid = 1'b1;
                end
            end
        end
        else
        begin
            host_gap = 0;
            host_calm = 0;
            idle_run = 0;
        end
        in_valid <= nxt_in_valid;
        cfg_valid <= nxt_cfg_valid;
    end

    always @(negedge clk)
    begin : sink_drive
        int sink_hold;
        int sink_calm;
        if (!rst_n)
        begin
            sink_hold = 0;
            sink_calm = 0;
            out_ready <= 1'b0;
        end
        else
        begin
            if (sink_calm > 0)
                sink_calm--;
            else if ($urandom_range(0, 199) == 0)
                sink_calm = $urandom_range(40, 160);
            if (sink_hold > 0)
            begin
                sink_hold--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                sink_hold = draw_gap(sink_calm > 0);
            end
        end
    end

    always @(posedge clk)
    begin : observe
        result_t got;
        result_t want;
        item_t   tok;
        if (!rst_n)
        begin
            in_taken = 1'b0;
            cfg_taken = 1'b0;
        end
        else
        begin
            in_taken = in_valid && in_ready;
            cfg_taken = cfg_valid && cfg_ready;
            if (out_valid && out_ready)
            begin
                got = {arm, arm_bank, arm_count, arm_toggle, arm_source, arm_offset,
                       stall_res, address_write, device_address, configured_value,
                       line_state_value, phase_now};
                if (pending_arms.size() == 0)
                begin
                    arm_errors++;
                    if (arm_errors <= 10)
                        $display("%0t ns: result beat with none expected: %s",
                                 $time, describe_arm(got));
                end
                else
                begin
                    want = pending_arms.pop_front();
                    if (got !== want)
                    begin
                        arm_errors++;
                        if (arm_errors <= 10)
                        begin
                            $display("%0t ns: result mismatch", $time);
                            $display("  expected %s", describe_arm(want));
                            $display("  actual   %s", describe_arm(got));
                        end
                    end
                end
            end
            if (cfg_taken)
                apply_reg_write(cfg_index, cfg_data);
            if (in_taken)
            begin
                tok = {op, received_toggle, request, setup_value, setup_length};
                predict_arm(tok, want);
                pending_arms.push_back(want);
            end
        end
    end

    initial
    begin : run
        logic [15:0] req;
        logic [15:0] val;
        logic [15:0] len;
        logic [15:0] junk;
        int          goal;
        int          roll;
        ph_q = PH_SETUP;
        src_q = SRC_NONE;
        offset_q = '0;
        remain_q = '0;
        req_addr_q = '0;
        cur_addr_q = '0;
        rx_bank_q = 1'b0;
        tx_bank_q = 1'b0;
        cfg_val_q = 1'b0;
        line_state_q = '0;
        dev_len_r = DEVICE_DESC_LEN_RESET;
        cfg_len_r = CONFIG_DESC_LEN_RESET;
        mps_r = MAX_PACKET_SIZE_RESET;
        lc_len_r = LINE_CODING_LEN_RESET;

        // directed: every request, stalls, ignored tokens, address rules
        add_token(OP_BUS_RESET, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        add_transfer(REQ_GET_DESCRIPTOR, {DESC_TYPE_DEVICE, 8'h00}, 16'hFFFF);
        add_token(OP_IN, 16'h0000, 16'h0000, 16'h0000);
        add_transfer(REQ_SET_ADDRESS, 16'hFFFF, 16'h0000);
        add_transfer(REQ_SET_ADDRESS, 16'h007F, 16'h0040);
        add_transfer(REQ_GET_DESCRIPTOR, 16'h0600, 16'h000A);
        add_transfer(REQ_SET_CONFIGURATION, 16'h0002, 16'h0000);
        add_transfer(REQ_SET_CONFIGURATION, CONFIG_VALUE_ONE, 16'h0000);
        add_transfer(REQ_GET_CONFIGURATION, 16'h0000, 16'h0000);
        add_transfer(REQ_SET_CONTROL_LINE_STATE, 16'h00FF, 16'h0000);
        add_transfer(REQ_SET_LINE_CODING, 16'h0000, 16'h0007);
        add_transfer(16'hFFFF, 16'hFFFF, 16'hFFFF);
        add_reg_write(REG_MAX_PACKET_SIZE, 16'h0000);
        add_reg_write(REG_CONFIG_DESC_LEN, 16'hFFFF);
        add_transfer(REQ_GET_DESCRIPTOR, {DESC_TYPE_CONFIG, 8'hFF}, 16'd20);

        for (int stage = 0; stage < RANDOM_STAGES; stage++)
        begin
            // junk above the narrow register fields now and then
            junk = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'h0000;
            case (stage % 4)
                0: add_reg_write(REG_DEVICE_DESC_LEN, {junk[15:8], 8'd0});
                1: add_reg_write(REG_DEVICE_DESC_LEN, {junk[15:8], 8'd255});
                2: add_reg_write(REG_DEVICE_DESC_LEN, {junk[15:8], DEVICE_DESC_LEN_RESET});
                default: add_reg_write(REG_DEVICE_DESC_LEN, 16'($urandom));
            endcase
            case (stage % 4)
                0: add_reg_write(REG_CONFIG_DESC_LEN, 16'hFFFF);
                1: add_reg_write(REG_CONFIG_DESC_LEN, 16'h0000);
                2: add_reg_write(REG_CONFIG_DESC_LEN, 16'($urandom_range(0, 1000)));
                default: add_reg_write(REG_CONFIG_DESC_LEN, 16'($urandom));
            endcase
            case (stage)
                0: add_reg_write(REG_MAX_PACKET_SIZE, {junk[15:7], 7'd8});
                1: add_reg_write(REG_MAX_PACKET_SIZE, {junk[15:7], 7'd0});
                2: add_reg_write(REG_MAX_PACKET_SIZE, {junk[15:7], 7'd64});
                3: add_reg_write(REG_MAX_PACKET_SIZE, {junk[15:7], 7'd127});
                4: add_reg_write(REG_MAX_PACKET_SIZE, {junk[15:7], 7'd7});
                5: add_reg_write(REG_MAX_PACKET_SIZE, {junk[15:7], 7'd65});
                default: add_reg_write(REG_MAX_PACKET_SIZE, 16'($urandom));
            endcase
            case (stage % 4)
                0: add_reg_write(REG_LINE_CODING_LEN, {junk[15:8], 8'd255});
                1: add_reg_write(REG_LINE_CODING_LEN, {junk[15:8], LINE_CODING_LEN_RESET});
                2: add_reg_write(REG_LINE_CODING_LEN, {junk[15:8], 8'd0});
                default: add_reg_write(REG_LINE_CODING_LEN, 16'($urandom));
            endcase

            goal = token_total + STAGE_TOKENS;
            while (token_total < goal)
            begin
                roll = $urandom_range(0, 99);
                val = 16'($urandom);
                if (roll < 88)
                begin
                    if (roll < 25)
                    begin
                        req = REQ_GET_DESCRIPTOR;
                        if ($urandom_range(0, 9) < 8)
                            val[15:8] = 8'($urandom_range(1, 2));
                    end
                    else if (roll < 33)
                        req = REQ_GET_CONFIGURATION;
                    else if (roll < 43)
                    begin
                        req = REQ_SET_CONFIGURATION;
                        if ($urandom_range(0, 3) != 0)
                            val = CONFIG_VALUE_ONE;
                    end
                    else if (roll < 55)
                        req = REQ_SET_ADDRESS;
                    else if (roll < 65)
                        req = REQ_SET_CONTROL_LINE_STATE;
                    else if (roll < 82)
                        req = REQ_SET_LINE_CODING;
                    else
                        req = 16'($urandom);
                    roll = $urandom_range(0, 9);
                    if (roll < 7)
                        len = 16'($urandom_range(0, 80));
                    else if (roll < 9)
                        len = 16'($urandom_range(0, 600));
                    else
                        len = 16'($urandom);
                    add_transfer(req, val, len);
                end
                else
                begin
                    // broken transfer or stray tokens, then a bus reset to realign
                    if ($urandom_range(0, 1) == 0)
                        add_token(OP_SETUP, REQ_GET_DESCRIPTOR,
                                  {DESC_TYPE_CONFIG, 8'($urandom)}, 16'($urandom));
                    repeat ($urandom_range(1, 4))
                        add_token(op_t'($urandom_range(0, 2)), 16'($urandom),
                                  16'($urandom), 16'($urandom));
                    add_token(OP_BUS_RESET, 16'($urandom), 16'($urandom), 16'($urandom));
                end
            end
        end

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        while (token_script.size() != 0 || in_valid || cfg_valid || pending_arms.size() != 0)
            @(posedge clk);
        // leave room for any stray beat to show up
        repeat (8) @(posedge clk);
        if (arm_errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin : watchdog
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
